// ===== rtl/qcn_pkg.sv =====
// Shared types, constants and helper functions for the quadtree corner neighbor pipeline.
package qcn_pkg;

	localparam int PATH_LEVELS = 16;
	localparam int PATH_W = 2 * PATH_LEVELS;
	localparam int LEN_W = 5;
	localparam int NUM_CELLS = 4;
	localparam int OFS_W = PATH_LEVELS + 2;

	// Corner code that lies diagonally opposite a quadrant digit, as an XOR distance.
	localparam logic [1:0] OPPOSITE_XOR = 2'd2;

	typedef logic [PATH_LEVELS-1:0] coord_t;

	// Per-axis step from the cell to result cell b, indexed [corner][b].
	localparam logic signed [1:0] DX_TABLE [4][4] = '{
		'{2'sd1, 2'sd0, 2'sd0, 2'sd1},
		'{2'sd0, -2'sd1, -2'sd1, 2'sd0},
		'{2'sd0, -2'sd1, -2'sd1, 2'sd0},
		'{2'sd1, 2'sd0, 2'sd0, 2'sd1}
	};
	localparam logic signed [1:0] DY_TABLE [4][4] = '{
		'{-2'sd1, -2'sd1, 2'sd0, 2'sd0},
		'{-2'sd1, -2'sd1, 2'sd0, 2'sd0},
		'{2'sd0, 2'sd0, 2'sd1, 2'sd1},
		'{2'sd0, 2'sd0, 2'sd1, 2'sd1}
	};

	// Bit l of the result is bit (len-1-l) of v; bits at or above len are zero.
	function automatic coord_t rev_shift(input coord_t v, input logic [LEN_W-1:0] len);
		coord_t rv;
		logic [LEN_W-1:0] sh;
		for (int i = 0; i < PATH_LEVELS; i++) begin
			rv[i] = v[PATH_LEVELS-1-i];
		end
		sh = LEN_W'(PATH_LEVELS) - len;
		return rv >> sh;
	endfunction

	typedef struct packed {
		logic sib;
		logic [1:0] corner;
		logic [LEN_W-1:0] len;
		logic [PATH_W-1:0] prefix;
		coord_t xr;
		coord_t yr;
	} dec_t;

	typedef struct packed {
		logic sib;
		logic [LEN_W-1:0] len;
		logic [PATH_W-1:0] prefix;
		coord_t [NUM_CELLS-1:0] nx;
		coord_t [NUM_CELLS-1:0] ny;
		logic [NUM_CELLS-1:0] ok;
	} off_t;

endpackage

// ===== rtl/qcn_decode.sv =====
// First stage: length clamp, sibling test and split of the path into x and y digit bits.
module qcn_decode
	import qcn_pkg::*;
#(
	parameter int MAX_LEVEL = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic [PATH_W-1:0] cell_path,
	input  logic [LEN_W-1:0]  path_length,
	input  logic [1:0]        corner,
	output dec_t              dec_s1
);

	localparam int LEN_LIM = (MAX_LEVEL < PATH_LEVELS) ? MAX_LEVEL : PATH_LEVELS;

	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-2:0] last_lvl;
	logic [1:0]       last_digit;
	dec_t             dec_d;

	always_comb begin
		if (path_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (path_length > LEN_W'(LEN_LIM)) begin
			len_eff = LEN_W'(LEN_LIM);
		end else begin
			len_eff = path_length;
		end
		last_lvl = (LEN_W-1)'(len_eff - LEN_W'(1));
		last_digit = 2'(cell_path >> {last_lvl, 1'b0});

		dec_d.sib = (corner ^ last_digit) == OPPOSITE_XOR;
		dec_d.corner = corner;
		dec_d.len = len_eff;
		for (int l = 0; l < PATH_LEVELS; l++) begin
			// A digit codes +x for 0 and 3, +y for 2 and 3.
			dec_d.xr[l] = (LEN_W'(l) < len_eff) & ~(cell_path[2*l] ^ cell_path[2*l+1]);
			dec_d.yr[l] = (LEN_W'(l) < len_eff) & cell_path[2*l+1];
			dec_d.prefix[2*l +: 2] = (LEN_W'(l) < len_eff - LEN_W'(1)) ?
				cell_path[2*l +: 2] : 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

// ===== rtl/qcn_offset.sv =====
// Second stage: integer coordinates, corner offsets and grid range check for the four cells.
module qcn_offset
	import qcn_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  dec_t dec_s1,
	output off_t off_s2
);

	coord_t                  x;
	coord_t                  y;
	logic signed [OFS_W-1:0] nx_w [NUM_CELLS];
	logic signed [OFS_W-1:0] ny_w [NUM_CELLS];
	off_t                    off_d;

	always_comb begin
		x = rev_shift(dec_s1.xr, dec_s1.len);
		y = rev_shift(dec_s1.yr, dec_s1.len);
		off_d.sib = dec_s1.sib;
		off_d.len = dec_s1.len;
		off_d.prefix = dec_s1.prefix;
		for (int b = 0; b < NUM_CELLS; b++) begin
			nx_w[b] = $signed({2'b00, x}) + OFS_W'(DX_TABLE[dec_s1.corner][b]);
			ny_w[b] = $signed({2'b00, y}) + OFS_W'(DY_TABLE[dec_s1.corner][b]);
			off_d.nx[b] = nx_w[b][PATH_LEVELS-1:0];
			off_d.ny[b] = ny_w[b][PATH_LEVELS-1:0];
			// Inside the grid means 0 <= n < 2^len on both axes.
			off_d.ok[b] = !nx_w[b][OFS_W-1] && !ny_w[b][OFS_W-1]
				&& ((nx_w[b][OFS_W-2:0] >> dec_s1.len) == '0)
				&& ((ny_w[b][OFS_W-2:0] >> dec_s1.len) == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s2 <= off_d;
		end
	end

endmodule

// ===== rtl/qcn_encode.sv =====
// Third stage: re-encoding of the shifted coordinates, or sibling paths, into the output register.
module qcn_encode
	import qcn_pkg::*;
(
	input  logic                            clk,
	input  logic                            en,
	input  off_t                            off_s2,
	output logic [NUM_CELLS-1:0][PATH_W-1:0] path_s3,
	output logic [NUM_CELLS-1:0]            ok_s3
);

	coord_t                           xs [NUM_CELLS];
	coord_t                           ys [NUM_CELLS];
	logic [LEN_W-2:0]                 last_lvl;
	logic [NUM_CELLS-1:0][PATH_W-1:0] path_d;
	logic [NUM_CELLS-1:0]             ok_d;
	logic [NUM_CELLS-1:0][PATH_W-1:0] enc;

	always_comb begin
		last_lvl = (LEN_W-1)'(off_s2.len - LEN_W'(1));
		for (int b = 0; b < NUM_CELLS; b++) begin
			xs[b] = rev_shift(off_s2.nx[b], off_s2.len);
			ys[b] = rev_shift(off_s2.ny[b], off_s2.len);
			for (int l = 0; l < PATH_LEVELS; l++) begin
				enc[b][2*l +: 2] = (LEN_W'(l) < off_s2.len) ?
					{ys[b][l], ~(xs[b][l] ^ ys[b][l])} : 2'b00;
			end
			if (off_s2.sib) begin
				path_d[b] = off_s2.prefix | (PATH_W'(b) << {last_lvl, 1'b0});
				ok_d[b] = 1'b1;
			end else begin
				path_d[b] = off_s2.ok[b] ? enc[b] : '0;
				ok_d[b] = off_s2.ok[b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			path_s3 <= path_d;
			ok_s3 <= ok_d;
		end
	end

endmodule

// ===== rtl/quadtree_corner_neighbors_core.sv =====
// Top level of the quadtree corner neighbor pipeline: stage control and port mapping.
//
//   Channel   Direction   Handshake            Payload
//   in        into core   in_valid/in_stall    cell_path, path_length, corner
//   out       from core   out_valid/out_stall  neighbor_path_0..3, neighbor_valid_0..3
//
// With out_stall low, a query passes through the decode, offset and encode registers before
// its result is presented on the out channel, and a new query can be transferred in every cycle.
// While out_stall holds a presented result, the items behind it wait.
// The three stages are the decode, the coordinate offset with range check, and the re-encode
// into the output register; each stage holds one item together with its own valid bit.
// A stage advances when it is empty or the stage after it advances, so bubbles are squeezed
// out and in_stall rises only when all three stages hold items and out_stall is high.
// Reset clears the three valid bits only; the data registers are left unreset.
module quadtree_corner_neighbors_core
	import qcn_pkg::*;
#(
	parameter int MAX_LEVEL = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PATH_W-1:0] cell_path,
	input  logic [LEN_W-1:0]  path_length,
	input  logic [1:0]        corner,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PATH_W-1:0] neighbor_path_0,
	output logic [PATH_W-1:0] neighbor_path_1,
	output logic [PATH_W-1:0] neighbor_path_2,
	output logic [PATH_W-1:0] neighbor_path_3,
	output logic              neighbor_valid_0,
	output logic              neighbor_valid_1,
	output logic              neighbor_valid_2,
	output logic              neighbor_valid_3
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic adv1;
	logic adv2;
	logic adv3;

	dec_t                             dec_s1;
	off_t                             off_s2;
	logic [NUM_CELLS-1:0][PATH_W-1:0] path_s3;
	logic [NUM_CELLS-1:0]             ok_s3;

	// A stage may load when it is empty or its current item moves on in the same cycle.
	assign adv3 = !valid_s3 || !out_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	qcn_decode #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_decode (
		.clk        (clk),
		.en         (adv1),
		.cell_path  (cell_path),
		.path_length(path_length),
		.corner     (corner),
		.dec_s1     (dec_s1)
	);

	qcn_offset u_offset (
		.clk   (clk),
		.en    (adv2),
		.dec_s1(dec_s1),
		.off_s2(off_s2)
	);

	qcn_encode u_encode (
		.clk    (clk),
		.en     (adv3),
		.off_s2 (off_s2),
		.path_s3(path_s3),
		.ok_s3  (ok_s3)
	);

	assign out_valid = valid_s3;
	assign neighbor_path_0 = path_s3[0];
	assign neighbor_path_1 = path_s3[1];
	assign neighbor_path_2 = path_s3[2];
	assign neighbor_path_3 = path_s3[3];
	assign neighbor_valid_0 = ok_s3[0];
	assign neighbor_valid_1 = ok_s3[1];
	assign neighbor_valid_2 = ok_s3[2];
	assign neighbor_valid_3 = ok_s3[3];

`ifndef NO_ASSERTIONS
	// The input side is held off only when every stage is occupied and the output is blocked.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_stall))
		else $error("input stalled while the pipeline has room");

	// An input transfer always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted query lost before the first stage");

	// A second-stage item moves into the output stage whenever the output stage is free.
	a_s2_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (!valid_s3 || !out_stall)) |=> valid_s3)
		else $error("item lost between offset and encode stages");

	// A cell outside the grid must report a zero path.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((neighbor_valid_0 || neighbor_path_0 == '0)
			&& (neighbor_valid_1 || neighbor_path_1 == '0)
			&& (neighbor_valid_2 || neighbor_path_2 == '0)
			&& (neighbor_valid_3 || neighbor_path_3 == '0)))
		else $error("invalid neighbor carries a nonzero path");
`endif

endmodule

// ===== tb/quadtree_corner_neighbors_core_test.sv =====
// Self-checking testbench for the quadtree corner neighbor core.
`timescale 1ns / 100ps

module quadtree_corner_neighbors_core_test
	import qcn_pkg::*;
();

	localparam int MAX_LEVEL = 16;

	// The run is cut off here. A correct run makes about 670 transfers, a quarter of them
	// facing a 75% idle sender and another quarter a 75% stalling receiver.
	localparam int CYCLE_LIMIT = 300000;

	// The receiver holds out_stall high this long once, so that the pipe fills and stalls
	// its input while the sender keeps offering queries.
	localparam int HOLD_OFF_CYCLES = 64;

	localparam int ITEMS_PER_PHASE = 150;

	// Quadrant codes. Corners use the same codes: a corner is named by the quadrant it
	// points into.
	localparam logic [1:0] QUAD_PX_NY = 2'd0;
	localparam logic [1:0] QUAD_NX_NY = 2'd1;
	localparam logic [1:0] QUAD_NX_PY = 2'd2;
	localparam logic [1:0] QUAD_PX_PY = 2'd3;

	// Step from the queried cell to surrounding cell b, indexed [corner][b].
	localparam int STEP_X [4][4] = '{
		'{1, 0, 0, 1},
		'{0, -1, -1, 0},
		'{0, -1, -1, 0},
		'{1, 0, 0, 1}
	};
	localparam int STEP_Y [4][4] = '{
		'{-1, -1, 0, 0},
		'{-1, -1, 0, 0},
		'{0, 0, 1, 1},
		'{0, 0, 1, 1}
	};

	// The four surrounding cells of one answer, index b = cell b.
	typedef struct packed {
		logic [3:0][PATH_W-1:0] path;
		logic [3:0] ok;
	} nbr_set_t;

	// One directed query. Where known is set, the answer is typed in by hand.
	typedef struct packed {
		logic [PATH_W-1:0] path;
		logic [LEN_W-1:0] len;
		logic [1:0] corner;
		logic known;
		nbr_set_t want;
	} query_row_t;

	localparam int DIR_N = 21;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [PATH_W-1:0] cell_path;
	logic [LEN_W-1:0]  path_length;
	logic [1:0]        corner;
	logic              out_valid;
	logic              out_stall;
	logic [PATH_W-1:0] neighbor_path_0;
	logic [PATH_W-1:0] neighbor_path_1;
	logic [PATH_W-1:0] neighbor_path_2;
	logic [PATH_W-1:0] neighbor_path_3;
	logic              neighbor_valid_0;
	logic              neighbor_valid_1;
	logic              neighbor_valid_2;
	logic              neighbor_valid_3;

	// Answers of accepted queries, oldest first, waiting for their result transfer.
	nbr_set_t awaited_sets [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off_pending = 0;

	// Directed queries: the corner cases of the grid, length zero and oversized lengths,
	// digits above the length, the sibling case, and every corner on one path.
	query_row_t directed_rows [0:DIR_N-1] = '{
		// A single-level cell at +x-y whose opposite corner is the grid center.
		'{32'h0000_0000, 5'd1, QUAD_NX_PY, 1'b1,
			'{path: {32'd3, 32'd2, 32'd1, 32'd0}, ok: 4'b1111}},
		// The -x-y cell of a one-level grid, at its outer corner: only itself survives.
		'{32'h0000_0001, 5'd1, QUAD_NX_NY, 1'b1,
			'{path: {32'd1, 32'd0, 32'd0, 32'd0}, ok: 4'b1000}},
		// The top right cell of the finest grid, at its outer corner.
		'{32'hFFFF_FFFF, 5'd16, QUAD_PX_PY, 1'b1,
			'{path: {32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0}, ok: 4'b0010}},
		// The bottom left cell of the finest grid, at its outer corner.
		'{32'h5555_5555, 5'd16, QUAD_NX_NY, 1'b1,
			'{path: {32'h5555_5555, 32'd0, 32'd0, 32'd0}, ok: 4'b1000}},
		// The bottom right cell: the one valid cell has path zero.
		'{32'h0000_0000, 5'd16, QUAD_PX_NY, 1'b1,
			'{path: {32'd0, 32'd0, 32'd0, 32'd0}, ok: 4'b0100}},
		// The top left cell, at its outer corner.
		'{32'hAAAA_AAAA, 5'd16, QUAD_NX_PY, 1'b1,
			'{path: {32'd0, 32'd0, 32'd0, 32'hAAAA_AAAA}, ok: 4'b0001}},
		'{32'hFFFF_FFFC, 5'd0, QUAD_NX_NY, 1'b0, '0},
		'{32'hFFFF_FFFF, 5'd0, QUAD_PX_NY, 1'b0, '0},
		'{32'h1234_5678, 5'd31, QUAD_NX_NY, 1'b0, '0},
		'{32'h8765_4321, 5'd17, QUAD_PX_PY, 1'b0, '0},
		'{32'h1234_5678, 5'd16, QUAD_PX_NY, 1'b0, '0},
		'{32'h1234_5678, 5'd16, QUAD_NX_NY, 1'b0, '0},
		'{32'h1234_5678, 5'd16, QUAD_NX_PY, 1'b0, '0},
		'{32'h1234_5678, 5'd16, QUAD_PX_PY, 1'b0, '0},
		'{32'hDEAD_BEEF, 5'd2, QUAD_PX_NY, 1'b0, '0},
		'{32'hCAFE_0006, 5'd2, QUAD_NX_PY, 1'b0, '0},
		'{32'hF0F0_F0F0, 5'd8, QUAD_NX_NY, 1'b0, '0},
		'{32'h0F0F_0F0F, 5'd8, QUAD_PX_PY, 1'b0, '0},
		'{32'h0000_0003, 5'd1, QUAD_NX_NY, 1'b0, '0},
		'{32'h0000_0002, 5'd1, QUAD_PX_NY, 1'b0, '0},
		'{32'h7FFF_FFFF, 5'd16, QUAD_NX_NY, 1'b0, '0}
	};

	quadtree_corner_neighbors_core #(
		.MAX_LEVEL(MAX_LEVEL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_path(cell_path),
		.path_length(path_length),
		.corner(corner),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.neighbor_path_0(neighbor_path_0),
		.neighbor_path_1(neighbor_path_1),
		.neighbor_path_2(neighbor_path_2),
		.neighbor_path_3(neighbor_path_3),
		.neighbor_valid_0(neighbor_valid_0),
		.neighbor_valid_1(neighbor_valid_1),
		.neighbor_valid_2(neighbor_valid_2),
		.neighbor_valid_3(neighbor_valid_3)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Length as the block uses it: zero counts as one, and no path holds more than
	// MAX_LEVEL or sixteen digits.
	function automatic int levels_used(logic [LEN_W-1:0] len_field);
		int n;
		n = int'(len_field);
		if (n < 1) n = 1;
		if (n > MAX_LEVEL) n = MAX_LEVEL;
		if (n > PATH_LEVELS) n = PATH_LEVELS;
		return n;
	endfunction

	// Packs grid coordinates into a path, the coarsest level in the lowest digit.
	function automatic logic [PATH_W-1:0] xy_to_path(int x, int y, int len);
		logic [PATH_W-1:0] p;
		logic xb;
		logic yb;
		logic [1:0] digit;
		p = '0;
		for (int l = 0; l < len; l++) begin
			xb = 1'((x >> (len - 1 - l)) & 1);
			yb = 1'((y >> (len - 1 - l)) & 1);
			if (xb && yb) digit = QUAD_PX_PY;
			else if (xb) digit = QUAD_PX_NY;
			else if (yb) digit = QUAD_NX_PY;
			else digit = QUAD_NX_NY;
			p[2*l +: 2] = digit;
		end
		return p;
	endfunction

	// The four cells of the same level that meet at the given corner of the cell.
	function automatic nbr_set_t corner_neighbors(logic [PATH_W-1:0] p,
			logic [LEN_W-1:0] len_field, logic [1:0] c);
		nbr_set_t r;
		int len;
		int x;
		int y;
		int nx;
		int ny;
		int span;
		logic [1:0] digit;
		logic [63:0] keep;
		len = levels_used(len_field);
		digit = p[2*(len-1) +: 2];
		r = '0;
		if ((c ^ digit) == OPPOSITE_XOR) begin
			// The corner is the center of the parent, so the answer is the four siblings.
			keep = (64'd1 << (2 * (len - 1))) - 64'd1;
			for (int b = 0; b < 4; b++) begin
				r.path[b] = (p & keep[PATH_W-1:0]) | (PATH_W'(b) << (2 * (len - 1)));
				r.ok[b] = 1'b1;
			end
			return r;
		end
		x = 0;
		y = 0;
		span = 1 << len;
		for (int l = 0; l < len; l++) begin
			digit = p[2*l +: 2];
			if (digit == QUAD_PX_NY || digit == QUAD_PX_PY) x += 1 << (len - 1 - l);
			if (digit == QUAD_NX_PY || digit == QUAD_PX_PY) y += 1 << (len - 1 - l);
		end
		for (int b = 0; b < 4; b++) begin
			nx = x + STEP_X[c][b];
			ny = y + STEP_Y[c][b];
			if (nx >= 0 && nx < span && ny >= 0 && ny < span) begin
				r.path[b] = xy_to_path(nx, ny, len);
				r.ok[b] = 1'b1;
			end
		end
		return r;
	endfunction

	// Offers one query and holds it until the block takes it. The answer is queued at
	// the transfer edge.
	task automatic offer_query(input logic [PATH_W-1:0] p, input logic [LEN_W-1:0] l,
			input logic [1:0] c, input logic known, input nbr_set_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_path <= p;
		path_length <= l;
		corner <= c;
		do @(posedge clk); while (in_stall !== 1'b0);
		awaited_sets.insert(awaited_sets.size(), known ? want : corner_neighbors(p, l, c));
	endtask

	// Random query. Most are built from coordinates, often on the grid's border, so that
	// the range check is hit on every side; the rest are raw random paths. Lengths are
	// mostly in range, with zero and oversized values now and then, and the digits above
	// the length are filled with noise.
	task automatic draw_query(output logic [PATH_W-1:0] p, output logic [LEN_W-1:0] l,
			output logic [1:0] c);
		int eff;
		int span;
		int x;
		int y;
		logic [63:0] used;
		case ($urandom_range(19))
			0: l = 5'd0;
			1: l = LEN_W'($urandom_range(31, 17));
			2, 3, 4: l = 5'd16;
			default: l = LEN_W'($urandom_range(15, 1));
		endcase
		c = 2'($urandom_range(3));
		eff = levels_used(l);
		if ($urandom_range(3) == 0) begin
			p = $urandom;
		end else begin
			span = 1 << eff;
			case ($urandom_range(3))
				0: x = 0;
				1: x = span - 1;
				default: x = $urandom_range(span - 1);
			endcase
			case ($urandom_range(3))
				0: y = 0;
				1: y = span - 1;
				default: y = $urandom_range(span - 1);
			endcase
			used = (64'd1 << (2 * eff)) - 64'd1;
			p = xy_to_path(x, y, eff) | ($urandom & ~used[PATH_W-1:0]);
		end
	endtask

	// Compares one result transfer with the oldest queued answer, cell by cell.
	task automatic check_result();
		nbr_set_t got;
		nbr_set_t want;
		got.path = {neighbor_path_3, neighbor_path_2, neighbor_path_1, neighbor_path_0};
		got.ok = {neighbor_valid_3, neighbor_valid_2, neighbor_valid_1, neighbor_valid_0};
		if (awaited_sets.size() == 0) begin
			$error("result transfer with no query outstanding");
			mismatches++;
			return;
		end
		want = awaited_sets.pop_front();
		for (int b = 0; b < 4; b++) begin
			if (got.path[b] !== want.path[b]) begin
				$error("neighbor_path_%0d: expected %h, actual %h", b, want.path[b],
					got.path[b]);
				mismatches++;
			end
			if (got.ok[b] !== want.ok[b]) begin
				$error("neighbor_valid_%0d: expected %b, actual %b", b, want.ok[b],
					got.ok[b]);
				mismatches++;
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_sets.size() != 0) @(posedge clk);
	endtask

	// Result side. Outputs are sampled at the edge before the block updates them, so a
	// transfer is seen exactly when out_valid was high and out_stall low. The stall for
	// the next cycle is chosen afterwards, either from the current stall rate or from a
	// long hold-off that the stimulus asks for once.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
			if (hold_off_pending) begin
				hold_off_pending = 0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Stimulus: reset, the directed table, then random queries under four idling mixes,
	// then a phase that backs up the pipe and one where the sender waits for the pipe to
	// empty.
	initial begin
		logic [PATH_W-1:0] p;
		logic [LEN_W-1:0] l;
		logic [1:0] c;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cell_path <= '0;
		path_length <= '0;
		corner <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			offer_query(directed_rows[i].path, directed_rows[i].len,
				directed_rows[i].corner, directed_rows[i].known, directed_rows[i].want);
		end

		// Phase 0 streams back to back; 1 starves the input; 2 backs up the output;
		// 3 puts light gaps on both sides.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 75; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 75; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				draw_query(p, l, c);
				offer_query(p, l, c, 1'b0, '0);
			end
			drain_results();
		end

		// The receiver holds off for a long stretch while queries keep coming, so all
		// three stages fill and in_stall must rise; then the sender pauses until every
		// answer is back before the last burst.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_pending = 1;
		for (int k = 0; k < 30; k++) begin
			draw_query(p, l, c);
			offer_query(p, l, c, 1'b0, '0);
		end
		drain_results();
		for (int k = 0; k < 20; k++) begin
			draw_query(p, l, c);
			offer_query(p, l, c, 1'b0, '0);
		end
		drain_results();

		// Idle time after the last answer lets a stray extra result from the three stages be caught.
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
